// File: rtl/mhc_pkg.sv
// ----------------------------------------------------------------------------
// mhc_pkg: shared types and constants of the compass heading block
// Widths, the CORDIC arctangent table and the records passed down the pipe.
// ----------------------------------------------------------------------------
package mhc_pkg;

	localparam int CORDIC_STAGES       = 16;
	localparam int SCALE_FRACTION_BITS = 12;

	localparam int ATAN_ENTRIES = 24;
	localparam int NUM_CELLS    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
	localparam int STAGE_W      = $clog2(ATAN_ENTRIES);

	// x and y carry 16 fraction bits; 36 bits cover the CORDIC gain with margin
	localparam int CORDIC_W = 36;
	localparam int ANGLE_W  = 32;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;

	localparam logic [15:0]        SCALE_RESET = 16'd4096;
	localparam logic [ANGLE_W-1:0] HALF_TURN   = 32'h8000_0000;

	localparam logic [8:0] DEG_ZERO  = 9'd0;
	localparam logic [8:0] DEG_EAST  = 9'd90;
	localparam logic [8:0] DEG_SOUTH = 9'd180;
	localparam logic [8:0] DEG_WEST  = 9'd270;
	localparam logic [8:0] DEG_FULL  = 9'd360;

	// atan(2^-i) as a fraction of one turn, 2^32 per turn
	localparam logic [ANGLE_W-1:0] ATAN_TURN [ATAN_ENTRIES] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	typedef struct packed {
		logic signed [15:0] bias_x;
		logic signed [15:0] bias_y;
		logic signed [15:0] bias_z;
		logic [15:0]        scale_x;
		logic [15:0]        scale_y;
		logic [15:0]        scale_z;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic signed [15:0] cz;
		logic               clip;
	} sample_t;

	typedef struct packed {
		sample_t                    smp;
		logic                       fixed;
		logic [8:0]                 fixed_deg;
		logic signed [CORDIC_W-1:0] x;
		logic signed [CORDIC_W-1:0] y;
		logic [ANGLE_W-1:0]         z;
	} cordic_t;

endpackage

// File: rtl/mhc_in_if.sv
// ----------------------------------------------------------------------------
// mhc_in_if: raw sample channel
// Valid/ready channel carrying one three-axis magnetometer reading.
// ----------------------------------------------------------------------------
interface mhc_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] raw_x;
	logic signed [15:0] raw_y;
	logic signed [15:0] raw_z;

	modport source (output valid, output raw_x, output raw_y, output raw_z, input ready);
	modport sink   (input valid, input raw_x, input raw_y, input raw_z, output ready);
endinterface

// File: rtl/mhc_out_if.sv
// ----------------------------------------------------------------------------
// mhc_out_if: heading result channel
// Valid/ready channel carrying corrected axes, heading and compass sector.
// ----------------------------------------------------------------------------
interface mhc_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] corrected_x;
	logic signed [15:0] corrected_y;
	logic signed [15:0] corrected_z;
	logic [8:0]         heading_degrees;
	logic [2:0]         compass_sector;
	logic               saturated;

	modport source (
		output valid, output corrected_x, output corrected_y, output corrected_z,
		output heading_degrees, output compass_sector, output saturated,
		input ready
	);
	modport sink (
		input valid, input corrected_x, input corrected_y, input corrected_z,
		input heading_degrees, input compass_sector, input saturated,
		output ready
	);
endinterface

// File: rtl/compass_heading_from_magnetometer.sv
// ----------------------------------------------------------------------------
// compass_heading_from_magnetometer: magnetometer sample to compass heading
// Calibration, unrolled CORDIC atan2 as a chain of cells, degree conversion.
// ----------------------------------------------------------------------------
// Registers: correction s1, s2, a register per CORDIC cell, heading s1, result.
// Throughput: one sample per cycle; each pipeline register holds while the next is full.
// Rate is set by the one-rotation-per-cell CORDIC chain and single multiplies per stage.
// Reset clears pipeline valids and loads biases 0, gains 4096; no clearing pass.
module compass_heading_from_magnetometer import mhc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	mhc_in_if.sink            sample,
	mhc_out_if.source         result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t    cfg;
	logic    link_valid [NUM_CELLS+1];
	logic    link_ready [NUM_CELLS+1];
	cordic_t link_data  [NUM_CELLS+1];

	mhc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mhc_correct u_correct (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.sample    (sample),
		.out_valid (link_valid[0]),
		.out_data  (link_data[0]),
		.out_ready (link_ready[0])
	);

	for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
		mhc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.stage     (STAGE_W'(g)),
			.in_valid  (link_valid[g]),
			.in_data   (link_data[g]),
			.in_ready  (link_ready[g]),
			.out_valid (link_valid[g+1]),
			.out_data  (link_data[g+1]),
			.out_ready (link_ready[g+1])
		);
	end

	mhc_heading u_heading (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (link_valid[NUM_CELLS]),
		.in_data  (link_data[NUM_CELLS]),
		.in_ready (link_ready[NUM_CELLS]),
		.result   (result)
	);

endmodule

// File: rtl/mhc_regs.sv
// ----------------------------------------------------------------------------
// mhc_regs: calibration register file
// APB-style access to the hard-iron biases and soft-iron gains.
// ----------------------------------------------------------------------------
module mhc_regs import mhc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	typedef enum logic [2:0] {
		REG_BIAS_X  = 3'd0,
		REG_BIAS_Y  = 3'd1,
		REG_BIAS_Z  = 3'd2,
		REG_SCALE_X = 3'd3,
		REG_SCALE_Y = 3'd4,
		REG_SCALE_Z = 3'd5
	} reg_idx_t;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bias_x  <= '0;
			cfg_q.bias_y  <= '0;
			cfg_q.bias_z  <= '0;
			cfg_q.scale_x <= SCALE_RESET;
			cfg_q.scale_y <= SCALE_RESET;
			cfg_q.scale_z <= SCALE_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_BIAS_X:  cfg_q.bias_x  <= pwdata[15:0];
				REG_BIAS_Y:  cfg_q.bias_y  <= pwdata[15:0];
				REG_BIAS_Z:  cfg_q.bias_z  <= pwdata[15:0];
				REG_SCALE_X: cfg_q.scale_x <= pwdata[15:0];
				REG_SCALE_Y: cfg_q.scale_y <= pwdata[15:0];
				REG_SCALE_Z: cfg_q.scale_z <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_BIAS_X:  prdata[15:0] = cfg_q.bias_x;
			REG_BIAS_Y:  prdata[15:0] = cfg_q.bias_y;
			REG_BIAS_Z:  prdata[15:0] = cfg_q.bias_z;
			REG_SCALE_X: prdata[15:0] = cfg_q.scale_x;
			REG_SCALE_Y: prdata[15:0] = cfg_q.scale_y;
			REG_SCALE_Z: prdata[15:0] = cfg_q.scale_z;
			default:     prdata = '0;
		endcase
	end

endmodule

// File: rtl/mhc_correct.sv
// ----------------------------------------------------------------------------
// mhc_correct: hard/soft-iron correction and CORDIC set-up
// Subtract bias, scale, truncate and saturate; fold x into the right half.
// ----------------------------------------------------------------------------
module mhc_correct import mhc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	mhc_in_if.sink sample,
	output logic   out_valid,
	output cordic_t out_data,
	input  logic   out_ready
);

	localparam logic [33:0] RND_MASK = (34'd1 << SCALE_FRACTION_BITS) - 34'd1;

	logic signed [15:0] raw  [3];
	logic signed [15:0] bias [3];
	logic [15:0]        scale[3];
	logic signed [16:0] diff [3];
	logic signed [33:0] prod [3];

	logic               v_s1;
	logic signed [33:0] prod_s1 [3];
	logic               ready_s1;

	logic signed [33:0] tq   [3];
	logic signed [15:0] corr [3];
	logic [2:0]         clip;
	logic signed [CORDIC_W-1:0] xe, ye;
	cordic_t            prep;

	logic    v_s2;
	cordic_t d_s2;
	logic    ready_s2;

	assign ready_s2     = !v_s2 || out_ready;
	assign ready_s1     = !v_s1 || ready_s2;
	assign sample.ready = ready_s1;

	always_comb begin
		raw[0]   = sample.raw_x;
		raw[1]   = sample.raw_y;
		raw[2]   = sample.raw_z;
		bias[0]  = cfg.bias_x;
		bias[1]  = cfg.bias_y;
		bias[2]  = cfg.bias_z;
		scale[0] = cfg.scale_x;
		scale[1] = cfg.scale_y;
		scale[2] = cfg.scale_z;
		for (int a = 0; a < 3; a++) begin
			diff[a] = 17'(raw[a]) - 17'(bias[a]);
			prod[a] = diff[a] * $signed({1'b0, scale[a]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && sample.valid) begin
			for (int a = 0; a < 3; a++) prod_s1[a] <= prod[a];
		end
	end

	// truncate toward zero: add the fraction mask to negatives before the shift
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			tq[a] = (prod_s1[a] + $signed(prod_s1[a][33] ? RND_MASK : 34'd0))
				>>> SCALE_FRACTION_BITS;
			if (tq[a] > 34'sd32767) begin
				corr[a] = 16'sh7fff;
				clip[a] = 1'b1;
			end else if (tq[a] < -34'sd32768) begin
				corr[a] = 16'sh8000;
				clip[a] = 1'b1;
			end else begin
				corr[a] = tq[a][15:0];
				clip[a] = 1'b0;
			end
		end

		prep.smp.cx   = corr[0];
		prep.smp.cy   = corr[1];
		prep.smp.cz   = corr[2];
		prep.smp.clip = |clip;

		xe = $signed({{(CORDIC_W-32){corr[0][15]}}, corr[0], 16'h0000});
		ye = $signed({{(CORDIC_W-32){corr[1][15]}}, corr[1], 16'h0000});
		if (corr[0][15]) begin
			prep.x = -xe;
			prep.y = -ye;
			prep.z = HALF_TURN;
		end else begin
			prep.x = xe;
			prep.y = ye;
			prep.z = '0;
		end

		// exact axes and the zero vector bypass the CORDIC result
		prep.fixed     = 1'b1;
		prep.fixed_deg = DEG_ZERO;
		if (corr[1] == 16'sd0) begin
			prep.fixed_deg = corr[0][15] ? DEG_SOUTH : DEG_ZERO;
		end else if (corr[0] == 16'sd0) begin
			prep.fixed_deg = corr[1][15] ? DEG_WEST : DEG_EAST;
		end else begin
			prep.fixed = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			d_s2 <= prep;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = d_s2;

	a_folded_x: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> !d_s2.x[CORDIC_W-1])
		else $error("CORDIC start vector not folded into right half-plane");

endmodule

// File: rtl/mhc_cell.sv
// ----------------------------------------------------------------------------
// mhc_cell: one CORDIC vectoring micro-rotation
// Rotates toward the x axis by atan(2^-stage) and hands on to the next cell.
// ----------------------------------------------------------------------------
module mhc_cell import mhc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [STAGE_W-1:0] stage,
	input  logic               in_valid,
	input  cordic_t            in_data,
	output logic               in_ready,
	output logic               out_valid,
	output cordic_t            out_data,
	input  logic               out_ready
);

	logic signed [CORDIC_W-1:0] dx, dy;
	cordic_t nxt;
	logic    v_q;
	cordic_t d_q;

	assign in_ready = !v_q || out_ready;

	always_comb begin
		nxt = in_data;
		dx  = $signed(in_data.x) >>> stage;
		dy  = $signed(in_data.y) >>> stage;
		if (!in_data.y[CORDIC_W-1]) begin
			nxt.x = in_data.x + dy;
			nxt.y = in_data.y - dx;
			nxt.z = in_data.z + ATAN_TURN[stage];
		end else begin
			nxt.x = in_data.x - dy;
			nxt.y = in_data.y + dx;
			nxt.z = in_data.z - ATAN_TURN[stage];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_q <= nxt;
		end
	end

	assign out_valid = v_q;
	assign out_data  = d_q;

	// x only grows once folded into the right half-plane
	a_x_positive: assert property (@(posedge clk) disable iff (!arst_n)
		v_q |-> !d_q.x[CORDIC_W-1])
		else $error("CORDIC x went negative");

endmodule

// File: rtl/mhc_heading.sv
// ----------------------------------------------------------------------------
// mhc_heading: angle to degrees and compass sector
// Scales the turn fraction to whole degrees and drives the result register.
// ----------------------------------------------------------------------------
module mhc_heading import mhc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  cordic_t    in_data,
	output logic       in_ready,
	mhc_out_if.source  result
);

	typedef enum logic [2:0] {
		SECT_N  = 3'd0,
		SECT_NE = 3'd1,
		SECT_E  = 3'd2,
		SECT_SE = 3'd3,
		SECT_S  = 3'd4,
		SECT_SW = 3'd5,
		SECT_W  = 3'd6,
		SECT_NW = 3'd7
	} sector_t;

	localparam logic [8:0] EDGE_NE = 9'd23;
	localparam logic [8:0] EDGE_E  = 9'd68;
	localparam logic [8:0] EDGE_SE = 9'd113;
	localparam logic [8:0] EDGE_S  = 9'd158;
	localparam logic [8:0] EDGE_SW = 9'd203;
	localparam logic [8:0] EDGE_W  = 9'd248;
	localparam logic [8:0] EDGE_NW = 9'd293;
	localparam logic [8:0] EDGE_N  = 9'd338;

	function automatic sector_t sector_of(input logic [8:0] d);
		sector_t s;
		if (d >= EDGE_N || d < EDGE_NE) s = SECT_N;
		else if (d < EDGE_E)            s = SECT_NE;
		else if (d < EDGE_SE)           s = SECT_E;
		else if (d < EDGE_S)            s = SECT_SE;
		else if (d < EDGE_SW)           s = SECT_S;
		else if (d < EDGE_W)            s = SECT_SW;
		else if (d < EDGE_NW)           s = SECT_W;
		else                            s = SECT_NW;
		return s;
	endfunction

	logic [ANGLE_W+8:0] turn_prod;
	logic [8:0]         deg;

	logic       v_s1;
	sample_t    smp_s1;
	logic [8:0] deg_s1;
	logic       ready_s1;

	logic       res_valid_q;
	sample_t    res_smp_q;
	logic [8:0] res_deg_q;
	sector_t    res_sect_q;
	logic       res_ready;

	assign res_ready = !res_valid_q || result.ready;
	assign ready_s1  = !v_s1 || res_ready;
	assign in_ready  = ready_s1;

	always_comb begin
		turn_prod = (ANGLE_W+9)'(in_data.z) * (ANGLE_W+9)'(DEG_FULL);
		if (in_data.fixed) begin
			deg = in_data.fixed_deg;
		end else if (turn_prod[ANGLE_W+8:ANGLE_W] >= DEG_FULL) begin
			deg = DEG_ZERO;
		end else begin
			deg = turn_prod[ANGLE_W+8:ANGLE_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			smp_s1 <= in_data.smp;
			deg_s1 <= deg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_ready) begin
			res_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && v_s1) begin
			res_smp_q  <= smp_s1;
			res_deg_q  <= deg_s1;
			res_sect_q <= sector_of(deg_s1);
		end
	end

	assign result.valid           = res_valid_q;
	assign result.corrected_x     = res_smp_q.cx;
	assign result.corrected_y     = res_smp_q.cy;
	assign result.corrected_z     = res_smp_q.cz;
	assign result.saturated       = res_smp_q.clip;
	assign result.heading_degrees = res_deg_q;
	assign result.compass_sector  = res_sect_q;

	a_deg_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> res_deg_q < DEG_FULL)
		else $error("heading out of range");

	a_north_sector: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> ((res_deg_q >= EDGE_N || res_deg_q < EDGE_NE) == (res_sect_q == SECT_N)))
		else $error("sector disagrees with heading");

	a_zero_vector: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_smp_q.cx == 16'sd0 && res_smp_q.cy == 16'sd0
		|-> res_deg_q == DEG_ZERO)
		else $error("zero vector gave non-zero heading");

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: compass heading block testbench
// Drives raw magnetometer samples and calibration register writes, predicts
// the corrected axes, CORDIC heading, sector and clip flag of each sample,
// and checks every result in order, with random stalls on both channels outside the back-to-back test.
// ----------------------------------------------------------------------------
module tb_top;
	import mhc_pkg::*;

	localparam int  QUIET_LIMIT  = 2000;
	localparam int  DRAIN_CYCLES = 40;
	localparam real PI           = 3.14159265358979323846;

	// lower bound of each sector in degrees; north wraps through 0
	localparam int LIM_NE = 23;
	localparam int LIM_E  = 68;
	localparam int LIM_SE = 113;
	localparam int LIM_S  = 158;
	localparam int LIM_SW = 203;
	localparam int LIM_W  = 248;
	localparam int LIM_NW = 293;
	localparam int LIM_N  = 338;

	// atan(2^-i) in units of 2^-32 turn
	localparam logic [31:0] ATAN_STEP [24] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	typedef enum logic [2:0] {
		REG_BIAS_X, REG_BIAS_Y, REG_BIAS_Z,
		REG_SCALE_X, REG_SCALE_Y, REG_SCALE_Z,
		REG_UNUSED6, REG_UNUSED7
	} cal_reg_e;

	typedef enum logic [2:0] {
		PT_N, PT_NE, PT_E, PT_SE, PT_S, PT_SW, PT_W, PT_NW
	} compass_pt_e;

	typedef struct packed {
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic signed [15:0] cz;
		logic [8:0]         deg;
		logic [2:0]         sector;
		logic               sat;
	} heading_rec_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	mhc_in_if  smp ();
	mhc_out_if res ();

	cfg_t         cal;
	heading_rec_t expected_headings [$];
	int           samples_in;
	int           headings_out;
	int           n_errors;
	int           quiet_cycles;
	bit           no_idle;

	compass_heading_from_magnetometer DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (smp),
		.result  (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic signed [15:0] calibrate_axis(
		input logic signed [15:0] raw, input logic signed [15:0] offset,
		input logic [15:0] gain, output logic clipped);
		longint diff;
		longint g;
		longint prod;
		longint q;
		diff = raw;
		diff = diff - offset;
		g = gain;
		prod = diff * g;
		// truncate toward zero, not floor
		if (prod < 0)
			q = -((-prod) >>> SCALE_FRACTION_BITS);
		else
			q = prod >>> SCALE_FRACTION_BITS;
		clipped = 1'b0;
		if (q > 32767) begin
			q = 32767;
			clipped = 1'b1;
		end else if (q < -32768) begin
			q = -32768;
			clipped = 1'b1;
		end
		return q[15:0];
	endfunction

	function automatic logic [8:0] heading_of_xy(input logic signed [15:0] x,
		input logic signed [15:0] y);
		longint      vx;
		longint      vy;
		longint      dx;
		longint      dy;
		logic [31:0] ang;
		logic [63:0] wide;
		int          i;
		if (x == 0 && y == 0)
			return DEG_ZERO;
		if (y == 0)
			return (x > 0) ? DEG_ZERO : DEG_SOUTH;
		if (x == 0)
			return (y > 0) ? DEG_EAST : DEG_WEST;
		vx = x;
		vy = y;
		vx = vx * 65536;
		vy = vy * 65536;
		ang = '0;
		// fold the left half plane onto the right one
		if (vx < 0) begin
			vx = -vx;
			vy = -vy;
			ang = HALF_TURN;
		end
		for (i = 0; i < CORDIC_STAGES && i < 24; i++) begin
			dx = vx >>> i;
			dy = vy >>> i;
			if (vy >= 0) begin
				vx = vx + dy;
				vy = vy - dx;
				ang = ang + ATAN_STEP[i];
			end else begin
				vx = vx - dy;
				vy = vy + dx;
				ang = ang - ATAN_STEP[i];
			end
		end
		wide = ang;
		wide = wide * 360;
		if (wide[63:32] >= 360)
			return DEG_ZERO;
		return wide[40:32];
	endfunction

	function automatic compass_pt_e sector_of(input logic [8:0] deg);
		if (deg >= LIM_N || deg < LIM_NE) return PT_N;
		if (deg < LIM_E)  return PT_NE;
		if (deg < LIM_SE) return PT_E;
		if (deg < LIM_S)  return PT_SE;
		if (deg < LIM_SW) return PT_S;
		if (deg < LIM_W)  return PT_SW;
		if (deg < LIM_NW) return PT_W;
		return PT_NW;
	endfunction

	function automatic heading_rec_t predict_heading(input logic signed [15:0] rx,
		input logic signed [15:0] ry, input logic signed [15:0] rz);
		heading_rec_t h;
		logic         clip_x;
		logic         clip_y;
		logic         clip_z;
		h.cx = calibrate_axis(rx, cal.bias_x, cal.scale_x, clip_x);
		h.cy = calibrate_axis(ry, cal.bias_y, cal.scale_y, clip_y);
		h.cz = calibrate_axis(rz, cal.bias_z, cal.scale_z, clip_z);
		h.sat = clip_x | clip_y | clip_z;
		h.deg = heading_of_xy(h.cx, h.cy);
		h.sector = sector_of(h.deg);
		return h;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic flag_error(input string msg);
		if (n_errors < 40)
			$display("ERROR: %s", msg);
		n_errors++;
	endtask

	function automatic string field_msg(input string name, input longint got,
		input longint want);
		return $sformatf("result %0d: %s got %0d, want %0d", headings_out, name, got, want);
	endfunction

	// pop before push: a result at this edge belongs to an earlier sample
	always @(posedge clk) begin : score
		heading_rec_t want;
		if (arst_n && res.valid && res.ready) begin
			if (expected_headings.size() == 0) begin
				flag_error($sformatf("result after %0d arrived with nothing pending",
					headings_out));
			end else begin
				want = expected_headings.pop_front();
				if (res.corrected_x !== want.cx)
					flag_error(field_msg("corrected_x", res.corrected_x, want.cx));
				if (res.corrected_y !== want.cy)
					flag_error(field_msg("corrected_y", res.corrected_y, want.cy));
				if (res.corrected_z !== want.cz)
					flag_error(field_msg("corrected_z", res.corrected_z, want.cz));
				if (res.heading_degrees !== want.deg)
					flag_error(field_msg("heading_degrees", res.heading_degrees, want.deg));
				if (res.compass_sector !== want.sector)
					flag_error(field_msg("compass_sector", res.compass_sector, want.sector));
				if (res.saturated !== want.sat)
					flag_error(field_msg("saturated", res.saturated, want.sat));
				headings_out++;
			end
		end
		if (arst_n && smp.valid && smp.ready) begin
			expected_headings.push_back(predict_heading(smp.raw_x, smp.raw_y, smp.raw_z));
			samples_in++;
		end
	end

	always @(posedge clk) begin
		if ((smp.valid && smp.ready) || (res.valid && res.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- result side

	initial begin
		res.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!no_idle && $urandom_range(0, 2) == 0) begin
				res.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			res.ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic send_sample(input logic signed [15:0] rx, input logic signed [15:0] ry,
		input logic signed [15:0] rz);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			smp.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		smp.valid <= 1'b1;
		smp.raw_x <= rx;
		smp.raw_y <= ry;
		smp.raw_z <= rz;
		do @(posedge clk); while (!smp.ready);
	endtask

	// hold the sample side until every expected heading has come back
	task automatic wait_drained();
		smp.valid <= 1'b0;
		@(posedge clk);
		wait (headings_out == samples_in);
		@(posedge clk);
	endtask

	task automatic write_cal(input cal_reg_e idx, input logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_BIAS_X:  cal.bias_x  = value;
			REG_BIAS_Y:  cal.bias_y  = value;
			REG_BIAS_Z:  cal.bias_z  = value;
			REG_SCALE_X: cal.scale_x = value;
			REG_SCALE_Y: cal.scale_y = value;
			REG_SCALE_Z: cal.scale_z = value;
			default: ;
		endcase
		if (idx > REG_SCALE_Z) begin
			psel    <= 1'b0;
			penable <= 1'b0;
		end else begin
			// read back at the same address
			penable <= 1'b0;
			pwrite  <= 1'b0;
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			if (prdata[15:0] !== value)
				flag_error($sformatf("register %s read %h, want %h", idx.name(),
					prdata[15:0], value));
			psel    <= 1'b0;
			penable <= 1'b0;
		end
		// leave the bus idle before the next transfer
		@(posedge clk);
	endtask

	task automatic apply_calibration(input cfg_t c);
		write_cal(REG_BIAS_X, c.bias_x);
		write_cal(REG_BIAS_Y, c.bias_y);
		write_cal(REG_BIAS_Z, c.bias_z);
		write_cal(REG_SCALE_X, c.scale_x);
		write_cal(REG_SCALE_Y, c.scale_y);
		write_cal(REG_SCALE_Z, c.scale_z);
	endtask

	function automatic logic signed [15:0] clip16(input int v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic logic signed [15:0] pick_extreme();
		case ($urandom_range(0, 4))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return 16'shffff;
			default: return 16'sh0001;
		endcase
	endfunction

	function automatic logic [15:0] pick_bias();
		int v;
		case ($urandom_range(0, 9))
			0, 1: return 16'h0000;
			2, 3: return 16'($urandom);
			default: begin
				v = $urandom_range(0, 4000);
				return 16'(v - 2000);
			end
		endcase
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 19))
			0:  return 16'h0000;
			1:  return 16'hffff;
			2, 3: return 16'($urandom);
			4, 5, 6: return 16'($urandom_range(0, 1000));
			7, 8, 9: return 16'($urandom_range(60000, 65535));
			default: return 16'($urandom_range(3000, 6000));
		endcase
	endfunction

	// in the aimed modes x and y are set relative to the bias so that corrected vectors
	// sweep the whole circle, not just the saturated corners
	task automatic make_sample(output logic signed [15:0] rx, output logic signed [15:0] ry,
		output logic signed [15:0] rz);
		int  mode;
		int  j;
		int  tx;
		int  ty;
		real r;
		real a;
		mode = $urandom_range(0, 99);
		rz = 16'($urandom);
		tx = 0;
		ty = 0;
		if (mode < 40) begin
			rx = 16'($urandom);
			ry = 16'($urandom);
		end else if (mode < 55) begin
			rx = pick_extreme();
			ry = pick_extreme();
			rz = pick_extreme();
		end else begin
			if (mode < 65) begin
				tx = $urandom_range(0, 127);
				ty = $urandom_range(0, 127);
				tx = tx - 64;
				ty = ty - 64;
			end else if (mode < 75) begin
				j = $urandom_range(1, 20000);
				if ($urandom_range(0, 1))
					j = -j;
				if ($urandom_range(0, 1))
					tx = j;
				else
					ty = j;
			end else begin
				// whole-degree directions, nudged by at most one count
				r = $urandom_range(100, 20000);
				a = $urandom_range(0, 359) * PI / 180.0;
				j = $urandom_range(0, 2);
				tx = $rtoi(r * $cos(a)) + j - 1;
				j = $urandom_range(0, 2);
				ty = $rtoi(r * $sin(a)) + j - 1;
			end
			rx = clip16(tx + cal.bias_x);
			ry = clip16(ty + cal.bias_y);
		end
	endtask

	task automatic send_random(input int count);
		logic signed [15:0] rx;
		logic signed [15:0] ry;
		logic signed [15:0] rz;
		int                 i;
		for (i = 0; i < count; i++) begin
			make_sample(rx, ry, rz);
			send_sample(rx, ry, rz);
		end
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_directed_vectors();
		send_sample(16'sd0, 16'sd0, 16'sd0);
		send_sample(16'sd1000, 16'sd0, 16'sd5);
		send_sample(-16'sd1000, 16'sd0, -16'sd5);
		send_sample(16'sd0, 16'sd1000, 16'sd0);
		send_sample(16'sd0, -16'sd1000, 16'sd0);
		send_sample(16'sd1, 16'sd0, 16'sd0);
		send_sample(-16'sd1, 16'sd0, 16'sd0);
		send_sample(16'sd0, -16'sd1, 16'sd0);
		send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_sample(16'sh8000, 16'sh8000, 16'sh8000);
		send_sample(16'sh7fff, 16'sh8000, 16'sh0000);
		send_sample(16'sh8000, 16'sh7fff, 16'shffff);
		send_sample(16'sd1, 16'sd1, 16'sd0);
		send_sample(-16'sd1, 16'sd1, 16'sd0);
		send_sample(-16'sd1, -16'sd1, 16'sd0);
		send_sample(16'sd1, -16'sd1, 16'sd0);
		// just either side of north and south
		send_sample(16'sh7fff, -16'sd1, 16'sd0);
		send_sample(16'sh7fff, 16'sd1, 16'sd0);
		send_sample(16'sh8000, -16'sd1, 16'sd0);
		send_sample(16'sh8000, 16'sd1, 16'sd0);
		// near the north/north-east and south/south-west sector boundaries
		send_sample(16'sd10000, 16'sd4040, 16'sd0);
		send_sample(16'sd10000, 16'sd4245, 16'sd0);
		send_sample(-16'sd10000, -16'sd4245, 16'sd0);
	endtask

	task automatic test_calibration_extremes();
		cfg_t c;
		int   k;
		for (k = 0; k < 4; k++) begin
			wait_drained();
			case (k)
				0: begin
					c.bias_x = 16'h8000; c.bias_y = 16'h8000; c.bias_z = 16'h8000;
					c.scale_x = 16'hffff; c.scale_y = 16'hffff; c.scale_z = 16'hffff;
				end
				1: begin
					c.bias_x = 16'h7fff; c.bias_y = 16'h7fff; c.bias_z = 16'h7fff;
					c.scale_x = 16'h0000; c.scale_y = 16'h0000; c.scale_z = 16'h0000;
				end
				2: begin
					c.bias_x = 16'h0000; c.bias_y = 16'h0000; c.bias_z = 16'h0000;
					c.scale_x = 16'hffff; c.scale_y = 16'h0001; c.scale_z = SCALE_RESET;
				end
				default: begin
					c.bias_x = 16'($urandom); c.bias_y = 16'($urandom);
					c.bias_z = 16'($urandom);
					c.scale_x = SCALE_RESET; c.scale_y = 16'hffff; c.scale_z = 16'h0000;
				end
			endcase
			apply_calibration(c);
			if (k == 3) begin
				// writes past the last register must change nothing
				write_cal(REG_UNUSED6, 16'($urandom));
				write_cal(REG_UNUSED7, 16'($urandom));
			end
			send_sample(16'sh7fff, 16'sh8000, 16'sh7fff);
			send_sample(16'sh8000, 16'sh7fff, 16'sh8000);
			send_random(20);
		end
	endtask

	task automatic test_default_random();
		cfg_t c;
		wait_drained();
		c.bias_x = '0; c.bias_y = '0; c.bias_z = '0;
		c.scale_x = SCALE_RESET; c.scale_y = SCALE_RESET; c.scale_z = SCALE_RESET;
		apply_calibration(c);
		send_random(100);
	endtask

	task automatic test_random_calibration();
		cfg_t               c;
		logic signed [15:0] rx;
		logic signed [15:0] ry;
		logic signed [15:0] rz;
		int                 phase;
		int                 i;
		int                 pause_at;
		for (phase = 0; phase < 5; phase++) begin
			wait_drained();
			c.bias_x = pick_bias(); c.bias_y = pick_bias(); c.bias_z = pick_bias();
			c.scale_x = pick_gain(); c.scale_y = pick_gain(); c.scale_z = pick_gain();
			apply_calibration(c);
			pause_at = $urandom_range(10, 90);
			for (i = 0; i < 100; i++) begin
				if (i == pause_at)
					wait_drained();
				make_sample(rx, ry, rz);
				send_sample(rx, ry, rz);
			end
		end
	endtask

	task automatic test_back_to_back();
		cfg_t c;
		wait_drained();
		c.bias_x = pick_bias(); c.bias_y = pick_bias(); c.bias_z = pick_bias();
		c.scale_x = SCALE_RESET; c.scale_y = SCALE_RESET; c.scale_z = SCALE_RESET;
		apply_calibration(c);
		no_idle = 1'b1;
		send_random(150);
	endtask

	initial begin
		smp.valid <= 1'b0;
		smp.raw_x <= '0;
		smp.raw_y <= '0;
		smp.raw_z <= '0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		arst_n    <= 1'b0;
		no_idle = 1'b0;
		samples_in = 0;
		headings_out = 0;
		n_errors = 0;
		quiet_cycles = 0;
		cal.bias_x = '0;
		cal.bias_y = '0;
		cal.bias_z = '0;
		cal.scale_x = SCALE_RESET;
		cal.scale_y = SCALE_RESET;
		cal.scale_z = SCALE_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_vectors();
		test_calibration_extremes();
		test_default_random();
		test_random_calibration();
		test_back_to_back();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
